>>> src/ewc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes, widths and a saturation helper for the EWC update engine.
package ewc_pkg;

    localparam int MODE_W   = 2;
    localparam int IDX_W    = 5;
    localparam int VAL_W    = 32;
    localparam int PROD_W   = 66;
    localparam int OPND_W   = 33;
    localparam int LR_W     = 24;
    localparam int LAMBDA_W = 24;
    localparam int DECAY_W  = 16;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [MODE_W-1:0] MODE_UPDATE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONSOLIDATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD        = 2'd2;

    localparam logic [1:0] REG_LR     = 2'd0;
    localparam logic [1:0] REG_LAMBDA = 2'd1;
    localparam logic [1:0] REG_DECAY  = 2'd2;

    localparam logic [LR_W-1:0]     LR_RESET     = 24'd16777;
    localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 24'd25600;
    localparam logic [DECAY_W-1:0]  DECAY_RESET  = 16'd64881;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SQUARE,
        S_FISHER,
        S_PENALTY,
        S_PULL,
        S_STEP,
        S_SWEEP,
        S_DONE
    } t_state;

    function automatic logic signed [VAL_W-1:0] sat_s32(input logic signed [PROD_W-1:0] x);
        logic [PROD_W-VAL_W:0] top;
        top = x[PROD_W-1:VAL_W-1];
        if (top == '0 || top == '1) begin
            sat_s32 = x[VAL_W-1:0];
        end else if (x[PROD_W-1]) begin
            sat_s32 = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            sat_s32 = {1'b0, {(VAL_W-1){1'b1}}};
        end
    endfunction

endpackage

>>> src/ewc_req_if.sv
`timescale 1ns / 1ps
// Request channel carrying one update, consolidate or load command.
interface ewc_req_if;
    import ewc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [IDX_W-1:0]         index;
    logic signed [VAL_W-1:0]  value;

    modport source (output valid, output mode, output index, output value, input ready);
    modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

>>> src/ewc_rsp_if.sv
`timescale 1ns / 1ps
// Result channel carrying the outcome of one command.
interface ewc_rsp_if;
    import ewc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        done_mode;
    logic [IDX_W-1:0]         done_index;
    logic signed [VAL_W-1:0]  new_weight;
    logic [VAL_W-1:0]         new_fisher;

    modport source (output valid, output done_mode, output done_index, output new_weight,
                     output new_fisher, input ready);
    modport sink   (input valid, input done_mode, input done_index, input new_weight,
                     input new_fisher, output ready);
endinterface

>>> src/ewc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
module ewc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/ewc_regularized_weight_update.sv
`timescale 1ns / 1ps
// Top level of the elastic weight consolidation update engine.
//
// Requests arrive on i_req (mode, index, value) and each produces one result on
// o_rsp, except the unused mode code, which is taken and dropped. An update
// refreshes the Fisher estimate from the squared gradient and moves the weight
// against the gradient plus a pull toward its anchor. A consolidate copies every
// weight to its anchor. A load writes a weight and clears its Fisher and anchor.
// Weights, Fisher values and anchors live in three synchronous RAMs; the
// arithmetic runs on one shared 33 by 33 bit multiplier, one product per cycle.
// An update reads the RAMs, runs five dependent multiplies and writes back
// before the next request is accepted; a load or an out-of-range index skips
// the multiplies. A consolidate copies one RAM entry per cycle. After reset a
// clearing pass zeroes all three RAMs; no request is accepted meanwhile, while
// register writes are taken as usual. Results sit in an output register; the
// next request is accepted while a result waits, and the engine holds its last
// step until that register frees. The APB port holds learning rate, penalty
// strength and Fisher decay.
module ewc_regularized_weight_update #(
    parameter int PARAM_COUNT = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    ewc_req_if.sink                   i_req,
    ewc_rsp_if.source                 o_rsp,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ewc_pkg::APB_AW-1:0] paddr,
    input  logic [ewc_pkg::APB_DW-1:0] pwdata,
    output logic [ewc_pkg::APB_DW-1:0] prdata,
    output logic                      pready
);
    import ewc_pkg::*;

    localparam int AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
    localparam int CW = $clog2(PARAM_COUNT + 1);
    localparam int XW = AW + IDX_W;

    t_state r_state;
    t_state n_state;

    logic [LR_W-1:0]     r_lr;
    logic [LAMBDA_W-1:0] r_lambda;
    logic [DECAY_W-1:0]  r_decay;

    logic [CW-1:0]            r_cnt;
    logic                     r_cp_valid;
    logic [AW-1:0]            r_cp_addr;
    logic [MODE_W-1:0]        r_mode;
    logic [IDX_W-1:0]         r_idx;
    logic [AW-1:0]            r_addr;
    logic                     r_in_range;
    logic signed [VAL_W-1:0]  r_val;
    logic signed [VAL_W-1:0]  r_w;
    logic [VAL_W-1:0]         r_f;
    logic [VAL_W-1:0]         r_sq;
    logic [VAL_W-1:0]         r_dmag;
    logic                     r_dneg;
    logic                     r_sneg;
    logic signed [PROD_W-1:0] r_prod;

    logic                     r_out_valid;
    logic [MODE_W-1:0]        r_out_mode;
    logic [IDX_W-1:0]         r_out_idx;
    logic signed [VAL_W-1:0]  r_out_weight;
    logic [VAL_W-1:0]         r_out_fisher;

    logic [XW-1:0]  req_ext;
    logic [AW-1:0]  req_addr;
    logic           req_in_range;
    logic           req_take;
    logic           cfg_write;
    logic           out_free;
    logic           done_adv;
    logic [CW-1:0]  cnt_end;
    logic           clear_last;

    logic           w_we, f_we, a_we;
    logic [AW-1:0]  w_waddr, f_waddr, a_waddr, w_raddr;
    logic [VAL_W-1:0] w_wdata, f_wdata, a_wdata;
    logic [VAL_W-1:0] w_rdata, f_rdata, a_rdata;

    logic signed [OPND_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    logic [VAL_W-1:0]          val_u;
    logic [VAL_W-1:0]          gm;
    logic signed [VAL_W:0]     diff;
    logic [VAL_W-1:0]          sq_c;
    logic signed [OPND_W-1:0]  fdiff;
    logic signed [PROD_W-1:0]  fsum;
    logic [VAL_W-1:0]          f_c;
    logic [VAL_W-1:0]          p1_c;
    logic [PROD_W-25:0]        hi_mag;
    logic signed [PROD_W-1:0]  pen_w;
    logic signed [VAL_W-1:0]   pen_c;
    logic signed [PROD_W-1:0]  s_w;
    logic signed [VAL_W-1:0]   s_c;
    logic [VAL_W-1:0]          s_mag;
    logic signed [PROD_W-1:0]  w_w;
    logic signed [VAL_W-1:0]   w_new;

    assign req_ext      = {{AW{1'b0}}, i_req.index};
    assign req_addr     = req_ext[AW-1:0];
    assign req_in_range = req_ext < XW'(PARAM_COUNT);
    assign req_take     = i_req.valid && i_req.ready;
    assign cfg_write    = psel && penable && pwrite && pready;
    assign out_free     = !r_out_valid || o_rsp.ready;
    assign cnt_end      = CW'(PARAM_COUNT);
    assign clear_last   = r_cnt == CW'(PARAM_COUNT - 1);

    // Register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr     <= LR_RESET;
            r_lambda <= LAMBDA_RESET;
            r_decay  <= DECAY_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_LR:     r_lr     <= pwdata[LR_W-1:0];
                REG_LAMBDA: r_lambda <= pwdata[LAMBDA_W-1:0];
                REG_DECAY:  r_decay  <= pwdata[DECAY_W-1:0];
                default:    ;
            endcase
        end
    end

    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_LR:     prdata = {{(APB_DW-LR_W){1'b0}}, r_lr};
            REG_LAMBDA: prdata = {{(APB_DW-LAMBDA_W){1'b0}}, r_lambda};
            REG_DECAY:  prdata = {{(APB_DW-DECAY_W){1'b0}}, r_decay};
            default:    prdata = '0;
        endcase
    end

    // Arithmetic around the shared multiplier.
    always_comb begin
        val_u  = r_val;
        gm     = r_val[VAL_W-1] ? (32'd0 - val_u) : val_u;
        diff   = $signed({w_rdata[VAL_W-1], w_rdata}) - $signed({a_rdata[VAL_W-1], a_rdata});
        sq_c   = (r_prod[PROD_W-1:56] != '0) ? '1 : r_prod[55:24];
        fdiff  = $signed({1'b0, r_f}) - $signed({1'b0, sq_c});
        fsum   = $signed({18'd0, r_sq, 16'd0}) + r_prod;
        f_c    = (fsum[PROD_W-1:48] != '0) ? '1 : fsum[47:16];
        p1_c   = (r_prod[PROD_W-1:40] != '0) ? '1 : r_prod[39:8];
        hi_mag = r_prod[PROD_W-1:24];
        pen_w  = r_dneg ? -$signed({24'd0, hi_mag}) : $signed({24'd0, hi_mag});
        pen_c  = sat_s32(pen_w);
        s_w    = $signed({{34{r_val[VAL_W-1]}}, r_val}) + $signed({{34{pen_c[VAL_W-1]}}, pen_c});
        s_c    = sat_s32(s_w);
        s_mag  = s_c[VAL_W-1] ? (32'd0 - VAL_W'(s_c)) : VAL_W'(s_c);
        w_w    = r_sneg ? ($signed({{34{r_w[VAL_W-1]}}, r_w}) + $signed({24'd0, hi_mag}))
                        : ($signed({{34{r_w[VAL_W-1]}}, r_w}) - $signed({24'd0, hi_mag}));
        w_new  = sat_s32(w_w);
    end

    assign mul_p = mul_a * mul_b;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    unique case (i_req.mode)
                        MODE_UPDATE:      n_state = req_in_range ? S_SQUARE : S_DONE;
                        MODE_CONSOLIDATE: n_state = S_SWEEP;
                        MODE_LOAD:        n_state = S_DONE;
                        default:          n_state = S_IDLE;
                    endcase
                end
            end
            S_SQUARE:  n_state = S_FISHER;
            S_FISHER:  n_state = S_PENALTY;
            S_PENALTY: n_state = S_PULL;
            S_PULL:    n_state = S_STEP;
            S_STEP:    n_state = S_DONE;
            S_SWEEP: begin
                if (r_cnt == cnt_end && !r_cp_valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // Handshake, memory controls and multiplier operands.
    always_comb begin
        i_req.ready = 1'b0;
        done_adv    = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        w_raddr     = req_addr;
        unique case (r_state)
            S_CLEAR:   ;
            S_IDLE:    i_req.ready = 1'b1;
            S_SQUARE: begin
                mul_a = {1'b0, gm};
                mul_b = {1'b0, gm};
            end
            S_FISHER: begin
                mul_a = {17'd0, r_decay};
                mul_b = fdiff;
            end
            S_PENALTY: begin
                mul_a = {9'd0, r_lambda};
                mul_b = {1'b0, f_c};
            end
            S_PULL: begin
                mul_a = {1'b0, p1_c};
                mul_b = {1'b0, r_dmag};
            end
            S_STEP: begin
                mul_a = {9'd0, r_lr};
                mul_b = {1'b0, s_mag};
            end
            S_SWEEP:   w_raddr = r_cnt[AW-1:0];
            S_DONE:    done_adv = out_free;
        endcase
    end

    always_comb begin
        w_we    = (r_state == S_CLEAR)
                  || (done_adv && r_in_range && (r_mode == MODE_UPDATE || r_mode == MODE_LOAD));
        f_we    = w_we;
        a_we    = (r_state == S_CLEAR) || r_cp_valid
                  || (done_adv && r_in_range && r_mode == MODE_LOAD);
        w_waddr = (r_state == S_CLEAR) ? r_cnt[AW-1:0] : r_addr;
        f_waddr = w_waddr;
        a_waddr = (r_state == S_CLEAR) ? r_cnt[AW-1:0] : (r_cp_valid ? r_cp_addr : r_addr);
        if (r_state == S_CLEAR) begin
            w_wdata = '0;
            f_wdata = '0;
        end else if (r_mode == MODE_LOAD) begin
            w_wdata = r_val;
            f_wdata = '0;
        end else begin
            w_wdata = w_new;
            f_wdata = r_f;
        end
        a_wdata = r_cp_valid ? w_rdata : '0;
    end

    ewc_ram #(.WIDTH(VAL_W), .DEPTH(PARAM_COUNT)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ewc_ram #(.WIDTH(VAL_W), .DEPTH(PARAM_COUNT)) u_fisher_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (req_addr),
        .o_rdata (f_rdata)
    );

    ewc_ram #(.WIDTH(VAL_W), .DEPTH(PARAM_COUNT)) u_anchor_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (req_addr),
        .o_rdata (a_rdata)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_cp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cp_valid <= (r_state == S_SWEEP) && (r_cnt != cnt_end);
            if (r_state == S_CLEAR) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (req_take) begin
                r_cnt <= '0;
            end else if (r_state == S_SWEEP && r_cnt != cnt_end) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (done_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state != S_DONE) begin
            r_prod <= mul_p;
        end
        r_cp_addr <= r_cnt[AW-1:0];
        if (req_take) begin
            r_mode     <= i_req.mode;
            r_idx      <= i_req.index;
            r_addr     <= req_addr;
            r_in_range <= req_in_range;
            r_val      <= i_req.value;
        end
        if (r_state == S_SQUARE) begin
            r_w    <= w_rdata;
            r_f    <= f_rdata;
            r_dneg <= diff[VAL_W];
            r_dmag <= diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
        end
        if (r_state == S_FISHER) begin
            r_sq <= sq_c;
        end
        if (r_state == S_PENALTY) begin
            r_f <= f_c;
        end
        if (r_state == S_STEP) begin
            r_sneg <= s_c[VAL_W-1];
        end
        if (done_adv) begin
            r_out_mode <= r_mode;
            r_out_idx  <= (r_mode == MODE_CONSOLIDATE) ? '0 : r_idx;
            if (r_in_range && r_mode == MODE_UPDATE) begin
                r_out_weight <= w_new;
                r_out_fisher <= r_f;
            end else if (r_in_range && r_mode == MODE_LOAD) begin
                r_out_weight <= r_val;
                r_out_fisher <= '0;
            end else begin
                r_out_weight <= '0;
                r_out_fisher <= '0;
            end
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.done_mode  = r_out_mode;
    assign o_rsp.done_index = r_out_idx;
    assign o_rsp.new_weight = r_out_weight;
    assign o_rsp.new_fisher = r_out_fisher;

    a_copy_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_valid |-> r_state == S_SWEEP)
        else $error("anchor copy outside of consolidate sweep");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside of the completion step");

    a_consolidate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_mode == MODE_CONSOLIDATE)
        |-> (r_out_weight == '0 && r_out_fisher == '0 && r_out_idx == '0))
        else $error("consolidate result carries nonzero fields");

    a_load_fisher_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_mode == MODE_LOAD) |-> r_out_fisher == '0)
        else $error("load result carries a nonzero Fisher value");

    a_clear_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> (!r_out_valid && !i_req.ready))
        else $error("activity during the clearing pass");

endmodule

>>> test/ewc_update_checker.sv
`timescale 1ns / 1ps
// Checker for the EWC update engine: watches requests, results and register writes, and predicts and compares results.
module ewc_update_checker
    import ewc_pkg::*;
#(
    parameter int PARAM_COUNT = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ewc_req_if                i_req,
    ewc_rsp_if                i_rsp,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    input  logic              i_pready,
    output int                o_fail_count,
    output int                o_pending
);

    localparam longint S_MAX = 64'sd2147483647;
    localparam longint S_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] weight;
        logic [VAL_W-1:0]        fisher;
    } t_outcome;

    logic signed [VAL_W-1:0] weight_mem [PARAM_COUNT];
    logic [VAL_W-1:0]        fisher_mem [PARAM_COUNT];
    logic signed [VAL_W-1:0] anchor_mem [PARAM_COUNT];
    logic [LR_W-1:0]         lr_q;
    logic [LAMBDA_W-1:0]     lambda_q;
    logic [DECAY_W-1:0]      decay_q;

    t_outcome outcome_q [$];
    t_outcome predicted;
    t_outcome observed;
    t_outcome oldest;
    int       failures;

    function automatic longint widen(input logic signed [VAL_W-1:0] x);
        return x;
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp_s(input longint x);
        if (x > S_MAX) begin
            return S_MAX[VAL_W-1:0];
        end
        if (x < S_MIN) begin
            return S_MIN[VAL_W-1:0];
        end
        return x[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] clamp_u(input logic [63:0] x);
        return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[VAL_W-1:0];
    endfunction

    function automatic logic [63:0] abs64(input longint a);
        return (a < 0) ? -a : a;
    endfunction

    // Signed magnitude times an unsigned Q0.24 or Q8.24 factor, truncated toward zero.
    function automatic longint scale_q24(input longint a, input logic [63:0] m);
        logic [63:0] p;
        p = (abs64(a) * m) >> 24;
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic bit run_command(input logic [MODE_W-1:0] mode,
                                       input logic [IDX_W-1:0] idx,
                                       input logic signed [VAL_W-1:0] value,
                                       output t_outcome res);
        logic [63:0] gmag;
        logic [63:0] sq;
        logic [63:0] fis;
        logic [63:0] pull;
        longint      g;
        longint      diff;
        longint      pen;
        longint      s;
        longint      step;
        res = '0;
        res.mode = mode;
        res.index = idx;
        case (mode)
            MODE_CONSOLIDATE: begin
                for (int i = 0; i < PARAM_COUNT; i++) begin
                    anchor_mem[i] = weight_mem[i];
                end
                res.index = '0;
            end
            MODE_LOAD: begin
                if (idx < PARAM_COUNT) begin
                    weight_mem[idx] = value;
                    fisher_mem[idx] = '0;
                    anchor_mem[idx] = '0;
                    res.weight = value;
                end
            end
            MODE_UPDATE: begin
                if (idx < PARAM_COUNT) begin
                    g = widen(value);
                    gmag = abs64(g);
                    sq = clamp_u((gmag * gmag) >> 24);
                    fis = (64'(decay_q) * 64'(fisher_mem[idx])
                           + (64'd65536 - 64'(decay_q)) * sq) >> 16;
                    fis = clamp_u(fis);
                    fisher_mem[idx] = fis[VAL_W-1:0];
                    pull = clamp_u((64'(lambda_q) * fis) >> 8);
                    diff = widen(weight_mem[idx]) - widen(anchor_mem[idx]);
                    pen = widen(clamp_s(scale_q24(diff, pull)));
                    s = widen(clamp_s(g + pen));
                    step = scale_q24(s, 64'(lr_q));
                    weight_mem[idx] = clamp_s(widen(weight_mem[idx]) - step);
                    res.weight = weight_mem[idx];
                    res.fisher = fisher_mem[idx];
                end
            end
            default: begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    task automatic report_bad(input t_outcome want, input t_outcome seen, input bit orphan);
        if (failures < 10) begin
            if (orphan) begin
                $display("%0t: result with nothing expected: mode %0d index %0d weight %h fisher %h",
                         $realtime, seen.mode, seen.index, seen.weight, seen.fisher);
            end else begin
                $display("%0t: result mismatch (expected/actual): mode %0d/%0d index %0d/%0d",
                         $realtime, want.mode, seen.mode, want.index, seen.index);
                $display("    weight %h/%h fisher %h/%h",
                         want.weight, seen.weight, want.fisher, seen.fisher);
            end
        end
        failures++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PARAM_COUNT; i++) begin
                weight_mem[i] = '0;
                fisher_mem[i] = '0;
                anchor_mem[i] = '0;
            end
            lr_q = LR_RESET;
            lambda_q = LAMBDA_RESET;
            decay_q = DECAY_RESET;
            outcome_q.delete();
            failures = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                observed.mode = i_rsp.done_mode;
                observed.index = i_rsp.done_index;
                observed.weight = i_rsp.new_weight;
                observed.fisher = i_rsp.new_fisher;
                if (outcome_q.size() == 0) begin
                    report_bad(observed, observed, 1'b1);
                end else begin
                    oldest = outcome_q.pop_front();
                    if (observed !== oldest) begin
                        report_bad(oldest, observed, 1'b0);
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_AW-1:2])
                    REG_LR:     lr_q = i_pwdata[LR_W-1:0];
                    REG_LAMBDA: lambda_q = i_pwdata[LAMBDA_W-1:0];
                    REG_DECAY:  decay_q = i_pwdata[DECAY_W-1:0];
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                if (run_command(i_req.mode, i_req.index, i_req.value, predicted)) begin
                    outcome_q.push_back(predicted);
                end
            end
        end
        o_pending <= outcome_q.size();
        o_fail_count <= failures;
    end

endmodule

>>> test/tb_ewc_regularized_weight_update.sv
`timescale 1ns / 1ps
// Top-level testbench for the EWC update engine: clock, reset, stimulus, register writes and verdict.
module tb_ewc_regularized_weight_update;
    import ewc_pkg::*;

    localparam int                PARAM_COUNT  = 32;
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
    localparam int                DRAIN_CYCLES = PARAM_COUNT + 12;
    localparam int                HOLD_CYCLES  = 300;
    localparam int                PHASE_ITEMS  = 185;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    int                idle_pct;
    int                stall_pct;
    bit                hold_request;

    ewc_req_if req_ch ();
    ewc_rsp_if rsp_ch ();

    ewc_regularized_weight_update #(
        .PARAM_COUNT(PARAM_COUNT)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ewc_update_checker #(
        .PARAM_COUNT(PARAM_COUNT)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(10_000_000);
        $display("FAIL ewc_regularized_weight_update");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off when the stimulus asks for it.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic offer(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                         input logic [VAL_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode <= mode;
        req_ch.index <= idx;
        req_ch.value <= value;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] reg_sel, input logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            1, 2, 3, 4: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
            5, 6: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
            default: return $urandom();
        endcase
    endfunction

    // Most requests hit a few hot entries so that Fisher values and anchor pulls build up.
    task automatic run_random(input int count);
        int                count_done;
        int                roll;
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  idx;
        count_done = 0;
        while (count_done < count) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
                mode = MODE_UNUSED;
            end else if (roll < 12) begin
                mode = MODE_CONSOLIDATE;
            end else if (roll < 25) begin
                mode = MODE_LOAD;
            end else begin
                mode = MODE_UPDATE;
            end
            idx = ($urandom_range(99) < 70) ? IDX_W'($urandom_range(3))
                                            : IDX_W'($urandom_range(31));
            offer(mode, idx, pick_value());
            if (mode != MODE_UNUSED) begin
                count_done++;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_UPDATE;
        req_ch.index = '0;
        req_ch.value = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_request = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests under the reset register values.
        offer(MODE_UPDATE, 0, 32'h0000_0000);
        offer(MODE_UPDATE, 5, 32'h8000_0000);
        offer(MODE_UPDATE, 5, 32'h7FFF_FFFF);
        offer(MODE_LOAD, 0, 32'h7FFF_FFFF);
        offer(MODE_LOAD, 31, 32'h8000_0000);
        offer(MODE_UPDATE, 0, 32'h7FFF_FFFF);
        offer(MODE_UPDATE, 31, 32'h8000_0000);
        offer(MODE_UPDATE, 31, 32'h7FFF_FFFF);
        offer(MODE_CONSOLIDATE, 17, 32'h1234_5678);
        offer(MODE_UPDATE, 0, 32'h0100_0000);
        offer(MODE_LOAD, 1, 32'h0100_0000);
        offer(MODE_UPDATE, 1, 32'h0200_0000);
        offer(MODE_UPDATE, 1, 32'h0200_0000);
        offer(MODE_UPDATE, 1, 32'h0000_0000);
        offer(MODE_UNUSED, 31, 32'hFFFF_FFFF);
        offer(MODE_UNUSED, 0, 32'h0000_0000);
        offer(MODE_LOAD, 2, 32'hFFFF_FFFF);
        offer(MODE_UPDATE, 2, 32'hFFFF_FFFF);
        offer(MODE_CONSOLIDATE, 0, 32'h0000_0000);
        offer(MODE_UPDATE, 2, 32'h0000_0001);
        offer(MODE_LOAD, 31, 32'h0000_0000);
        offer(MODE_UPDATE, 31, 32'h0000_0000);
        wait_idle();

        for (int phase = 0; phase < 6; phase++) begin
            idle_pct = 0;
            stall_pct = 0;
            case (phase)
                0: begin
                    write_register(REG_LR, 32'h00FF_FFFF);
                    write_register(REG_LAMBDA, 32'h00FF_FFFF);
                    write_register(REG_DECAY, 32'h0000_0000);
                end
                1: begin
                    write_register(REG_LR, 32'h0000_0000);
                    write_register(REG_LAMBDA, 32'h0000_0000);
                    write_register(REG_DECAY, 32'h0000_FFFF);
                end
                2: begin
                    write_register(REG_LR, 32'h0010_0000);
                    write_register(REG_LAMBDA, 32'h0000_0100);
                    write_register(REG_DECAY, 32'h0000_8000);
                end
                4: begin
                    write_register(REG_LR, 32'h0040_0000);
                    write_register(REG_LAMBDA, 32'h0001_0000);
                    write_register(REG_DECAY, 32'h0000_FDF1);
                end
                default: begin
                    write_register(REG_LR, $urandom_range(32'h00FF_FFFF));
                    write_register(REG_LAMBDA, $urandom_range(32'h00FF_FFFF));
                    write_register(REG_DECAY, $urandom_range(32'h0000_FFFF));
                end
            endcase
            case (phase % 4)
                1: idle_pct = 74;
                2: stall_pct = 74;
                3: begin
                    idle_pct = 6;
                    stall_pct = 6;
                end
                default: ;
            endcase
            run_random(PHASE_ITEMS);
            wait_idle();
        end

        // Long receiver hold-off while requests keep coming, so the engine backs up.
        idle_pct = 0;
        stall_pct = 0;
        hold_request = 1'b1;
        repeat (24) offer(MODE_UPDATE, IDX_W'($urandom_range(3)), pick_value());
        wait_idle();

        if (fail_count == 0 && pending == 0) begin
            $display("PASS ewc_regularized_weight_update");
        end else begin
            $display("FAIL ewc_regularized_weight_update");
        end
        $finish;
    end

endmodule
